// ===== src/ppa_pkg.sv =====
package ppa_pkg;

    localparam int CFG_REG_COUNT = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int PRESS_BITS    = 16;
    localparam int LIMIT_BITS    = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALERT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_THR    = 2'd2;

    localparam logic [LIMIT_BITS-1:0] ACTIVE_LIMIT_RST = 32'd3000;
    localparam logic [LIMIT_BITS-1:0] ALERT_LIMIT_RST  = 32'd4000;
    // 5.0 in unsigned 8.8
    localparam logic [PRESS_BITS-1:0] PRESS_THR_RST    = 16'd1280;

    typedef logic [PRESS_BITS-1:0] press_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;

endpackage

// ===== src/presence_pressure_alarm_fsm_core.sv =====
// Channel  Handshake            Payload
// in       in_valid / in_ready  sensor_level, pressure, now_ms
// out      out_valid/ out_ready armed_status, alert_status, raise_alarm, clear_alarm
// cfg      cfg_we               cfg_addr, cfg_wdata
//
// One poll per cycle while in_ready is high; its result appears in the output register in the cycle after accept.
// The poll state is updated by one pass of compares and subtractions at accept.
// in_ready is high while the output register is empty or being taken this cycle.
// rst_n clears state and loads the register defaults; no clearing pass.
module presence_pressure_alarm_fsm_core
    import ppa_pkg::*;
#(
    parameter int TIME_BITS = 32
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     sensor_level,
    input  logic [15:0]              pressure,
    input  logic [31:0]              now_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     armed_status,
    output logic                     alert_status,
    output logic                     raise_alarm,
    output logic                     clear_alarm
);

    localparam int CW = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

    typedef logic [TIME_BITS-1:0] tm_t;

    limit_t active_limit_reg;
    limit_t alert_limit_reg;
    press_t press_thr_reg;

    logic sensor_on_reg,     sensor_on_next;
    logic level_seen_reg,    level_seen_next;
    logic prev_level_reg,    prev_level_next;
    tm_t  active_start_reg,  active_start_next;
    tm_t  release_time_reg,  release_time_next;
    logic alert_active_reg,  alert_active_next;
    logic alert_started_reg, alert_started_next;
    tm_t  alert_start_reg,   alert_start_next;
    logic alarm_sent_reg,    alarm_sent_next;
    logic raise_next;
    logic clear_next;

    logic out_valid_reg;
    logic armed_reg;
    logic alert_out_reg;
    logic raise_reg;
    logic clear_reg;

    logic [CW-1:0] now_wide;
    tm_t           now_t;
    tm_t           alert_elapsed;
    tm_t           held_time;
    logic          accept;

    assign now_wide = CW'(now_ms);
    assign now_t    = now_wide[TIME_BITS-1:0];
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sensor_on_next     = sensor_on_reg;
        level_seen_next    = level_seen_reg;
        prev_level_next    = prev_level_reg;
        active_start_next  = active_start_reg;
        release_time_next  = release_time_reg;
        alert_active_next  = alert_active_reg;
        alert_started_next = alert_started_reg;
        alert_start_next   = alert_start_reg;
        alarm_sent_next    = alarm_sent_reg;
        raise_next         = 1'b0;
        clear_next         = 1'b0;
        alert_elapsed      = alert_active_reg ? (now_t - alert_start_reg) : '0;
        held_time          = '0;

        if (alert_active_reg && sensor_level && !prev_level_reg)
        begin
            // re-press during alert
            sensor_on_next     = 1'b0;
            level_seen_next    = 1'b0;
            prev_level_next    = 1'b0;
            active_start_next  = '0;
            release_time_next  = '0;
            alert_active_next  = 1'b0;
            alert_started_next = 1'b0;
            alert_start_next   = '0;
            alarm_sent_next    = 1'b0;
            clear_next         = 1'b1;
        end
        else if (CW'(alert_elapsed) >= CW'(alert_limit_reg))
        begin
            // alert timeout, alarm_sent kept
            sensor_on_next     = 1'b0;
            alert_active_next  = 1'b0;
            alert_started_next = 1'b0;
            alert_start_next   = '0;
            level_seen_next    = 1'b0;
            active_start_next  = '0;
            prev_level_next    = 1'b0;
            release_time_next  = now_t;
        end
        else
        begin
            if (sensor_level)
            begin
                sensor_on_next    = 1'b1;
                release_time_next = '0;
                if (!level_seen_reg)
                begin
                    level_seen_next   = 1'b1;
                    active_start_next = now_t;
                end
            end
            else if (release_time_reg == '0 && level_seen_reg)
            begin
                release_time_next = now_t;
            end
            else if (!alert_active_reg && sensor_on_reg)
            begin
                sensor_on_next     = 1'b0;
                level_seen_next    = 1'b0;
                active_start_next  = '0;
                release_time_next  = '0;
                alert_active_next  = 1'b0;
                alert_started_next = 1'b0;
                alert_start_next   = '0;
                alarm_sent_next    = 1'b0;
            end
            prev_level_next = sensor_level;

            held_time = now_t - active_start_next;
            if (sensor_on_next && (CW'(held_time) >= CW'(active_limit_reg))
                && (pressure < press_thr_reg))
            begin
                release_time_next = '0;
                alert_active_next = 1'b1;
                if (!alert_started_reg)
                begin
                    alert_start_next   = now_t;
                    alert_started_next = 1'b1;
                end
                if (!alarm_sent_next)
                begin
                    raise_next      = 1'b1;
                    alarm_sent_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_limit_reg <= ACTIVE_LIMIT_RST;
            alert_limit_reg  <= ALERT_LIMIT_RST;
            press_thr_reg    <= PRESS_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ACTIVE_LIMIT: active_limit_reg <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_ALERT_LIMIT:  alert_limit_reg  <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_PRESS_THR:    press_thr_reg    <= cfg_wdata[PRESS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_on_reg     <= 1'b0;
            level_seen_reg    <= 1'b0;
            prev_level_reg    <= 1'b0;
            active_start_reg  <= '0;
            release_time_reg  <= '0;
            alert_active_reg  <= 1'b0;
            alert_started_reg <= 1'b0;
            alert_start_reg   <= '0;
            alarm_sent_reg    <= 1'b0;
        end
        else if (accept)
        begin
            sensor_on_reg     <= sensor_on_next;
            level_seen_reg    <= level_seen_next;
            prev_level_reg    <= prev_level_next;
            active_start_reg  <= active_start_next;
            release_time_reg  <= release_time_next;
            alert_active_reg  <= alert_active_next;
            alert_started_reg <= alert_started_next;
            alert_start_reg   <= alert_start_next;
            alarm_sent_reg    <= alarm_sent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            armed_reg     <= sensor_on_next;
            alert_out_reg <= alert_active_next;
            raise_reg     <= raise_next;
            clear_reg     <= clear_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign armed_status = armed_reg;
    assign alert_status = alert_out_reg;
    assign raise_alarm  = raise_reg;
    assign clear_alarm  = clear_reg;

endmodule
